// File: rtl/bsgt_pkg.sv
// Shared constants, codes and types of the batch sequence gap tracker.
package bsgt_pkg;

  localparam int unsigned HISTORY_DEPTH = 64;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam logic [63:0] U64_TOP       = '1;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_INVALID      = 3'd1,
    ST_DUPLICATE    = 3'd2,
    ST_GAP_REJECTED = 3'd3,
    ST_QUEUE_FULL   = 3'd4,
    ST_POPPED       = 3'd5,
    ST_EMPTY        = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REJECT_ON_GAP  = 2'd0,
    CFG_QUEUE_CAPACITY = 2'd1,
    CFG_MAX_SAMPLES    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_CMP  = 2'd1,
    FSM_DEC  = 2'd2
  } fsm_e;

  // window control: shift pushes a new entry, flush drops all older entries
  typedef struct packed {
    logic shift;
    logic flush;
  } win_ctrl_t;

endpackage

// File: rtl/bsgt_if.sv
// Handshake channels of the batch sequence gap tracker: input, result, configuration.
interface bsgt_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] session_tag;
  logic [63:0] batch_number;
  logic [63:0] first_sample_number;
  logic [15:0] samples_in_batch;

  modport source (output valid, mode, session_tag, batch_number, first_sample_number,
                  samples_in_batch, input ready);
  modport sink (input valid, mode, session_tag, batch_number, first_sample_number,
                samples_in_batch, output ready);
endinterface

interface bsgt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        session_restarted;
  logic        batch_gap_seen;
  logic [63:0] batches_missing;
  logic        batch_reordered;
  logic        sample_gap_seen;
  logic [63:0] samples_missing;
  logic        samples_reordered;
  logic [7:0]  queue_fill;

  modport source (output valid, status, session_restarted, batch_gap_seen, batches_missing,
                  batch_reordered, sample_gap_seen, samples_missing, samples_reordered,
                  queue_fill, input ready);
  modport sink (input valid, status, session_restarted, batch_gap_seen, batches_missing,
                batch_reordered, sample_gap_seen, samples_missing, samples_reordered,
                queue_fill, output ready);
endinterface

interface bsgt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bsgt_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [bsgt_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/bsgt_cell.sv
// One entry of the duplicate window: holds a batch number, shifts to its neighbor, compares.
module bsgt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bsgt_pkg::win_ctrl_t  ctrl_i,
  input  logic                 prev_valid_i,
  input  logic [63:0]          prev_value_i,
  input  logic [63:0]          probe_i,
  output logic                 valid_o,
  output logic [63:0]          value_o,
  output logic                 hit_o
);

  logic        valid_q, valid_d;
  logic [63:0] value_q;
  logic        hit_q, hit_d;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      valid_d = prev_valid_i;
    end else if (ctrl_i.flush) begin
      valid_d = 1'b0;
    end
    hit_d = valid_q && (value_q == probe_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      value_q <= prev_value_i;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign hit_o   = hit_q;

endmodule

// File: rtl/bsgt_window.sv
// Row of window cells holding the most recent recorded batch numbers (accepted or queue-full), newest first.
module bsgt_window (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bsgt_pkg::win_ctrl_t  ctrl_i,
  input  logic [63:0]          push_value_i,
  input  logic [63:0]          probe_i,
  output logic                 hit_o
);

  logic [bsgt_pkg::HISTORY_DEPTH-1:0] valid;
  logic [bsgt_pkg::HISTORY_DEPTH-1:0] hit;
  logic [63:0]                        value [bsgt_pkg::HISTORY_DEPTH];
  logic [bsgt_pkg::HISTORY_DEPTH-1:0] prev_valid;
  logic [63:0]                        prev_value [bsgt_pkg::HISTORY_DEPTH];

  for (genvar i = 0; i < int'(bsgt_pkg::HISTORY_DEPTH); i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b1;
      assign prev_value[i] = push_value_i;
    end else begin : g_body
      // on a flush only the newly pushed entry survives
      assign prev_valid[i] = valid[i-1] & ~ctrl_i.flush;
      assign prev_value[i] = value[i-1];
    end

    bsgt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .prev_valid_i (prev_valid[i]),
      .prev_value_i (prev_value[i]),
      .probe_i      (probe_i),
      .valid_o      (valid[i]),
      .value_o      (value[i]),
      .hit_o        (hit[i])
    );
  end

  assign hit_o = |hit;

endmodule

// File: rtl/batch_sequence_gap_tracker_top.sv
// Batch sequence gap tracker top level: session, high-water marks, window and queue count.
// One item is handled at a time: the beat is registered at the accepting edge, in the next
// cycle every window cell compares the batch number in parallel while the gap and reorder
// arithmetic runs, and in the cycle after that the hits are combined, the state is updated
// and the result is loaded into the output register. A new beat is taken as soon as the
// result sits in the output register, so an item is not taken before the last one is
// through; a stalled result holds the next item in the decision cycle.
// Session changes clear the window in the same update.
module batch_sequence_gap_tracker_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsgt_in_if.sink   in_i,
  bsgt_out_if.source out_o,
  bsgt_cfg_if.sink  cfg_i
);

  bsgt_pkg::fsm_e st_q, st_d;

  // configuration
  logic        rej_q;
  logic [7:0]  cap_q;
  logic [15:0] max_q;

  // item
  logic        mode_q;
  logic [63:0] tag_q, bnum_q, fnum_q;
  logic [15:0] nsmp_q;

  // tracking state
  logic        open_q, hwv_q;
  logic [63:0] cur_q, high_q, exp_q;
  logic [7:0]  cnt_q, cnt_d;

  // compare stage
  logic        new_sess_c, hwv_eff, b_above;
  logic [63:0] bdiff;
  logic [64:0] sum65;
  logic        new_sess_q, restarted_q, invalid_q, adv_q;
  logic        bgap_q, breord_q, sgap_q, sreord_q;
  logic [63:0] bmiss_q, smiss_q, end_q;

  // decision
  logic                win_hit_raw, win_hit, hit, out_adv, sess_upd, record;
  bsgt_pkg::status_e   res_status;
  logic                r_restart, r_bgap, r_breord, r_sgap, r_sreord;
  logic [63:0]         r_bmiss, r_smiss;
  bsgt_pkg::win_ctrl_t win_ctrl;

  // output register
  logic        ov_q;
  logic [2:0]  o_status_q;
  logic        o_restart_q, o_bgap_q, o_breord_q, o_sgap_q, o_sreord_q;
  logic [63:0] o_bmiss_q, o_smiss_q;
  logic [7:0]  o_fill_q;

  logic in_acc, cfg_acc;

  assign in_i.ready  = (st_q == bsgt_pkg::FSM_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  // ---------------- compare stage logic
  always_comb begin
    new_sess_c = !open_q || (cur_q != tag_q);
    hwv_eff    = hwv_q && !new_sess_c;
    bdiff      = bnum_q - high_q;
    b_above    = bnum_q > high_q;
    sum65      = {1'b0, fnum_q} + {49'd0, nsmp_q};
  end

  // ---------------- decision
  always_comb begin
    out_adv    = (st_q == bsgt_pkg::FSM_DEC) && (!ov_q || out_o.ready);
    sess_upd   = 1'b0;
    record     = 1'b0;
    cnt_d      = cnt_q;
    res_status = bsgt_pkg::ST_EMPTY;
    r_restart  = 1'b0;
    r_bgap     = 1'b0;
    r_breord   = 1'b0;
    r_sgap     = 1'b0;
    r_sreord   = 1'b0;
    r_bmiss    = '0;
    r_smiss    = '0;
    if (mode_q) begin
      if (cnt_q != 8'd0) begin
        cnt_d      = cnt_q - 8'd1;
        res_status = bsgt_pkg::ST_POPPED;
      end
    end else if (invalid_q) begin
      res_status = bsgt_pkg::ST_INVALID;
    end else begin
      sess_upd  = 1'b1;
      r_restart = restarted_q;
      if (hit) begin
        res_status = bsgt_pkg::ST_DUPLICATE;
      end else begin
        r_bgap   = bgap_q;
        r_bmiss  = bmiss_q;
        r_breord = breord_q;
        r_sgap   = sgap_q;
        r_smiss  = smiss_q;
        r_sreord = sreord_q;
        if ((bgap_q || sgap_q) && rej_q) begin
          res_status = bsgt_pkg::ST_GAP_REJECTED;
        end else begin
          record = 1'b1;
          if (cnt_q >= cap_q) begin
            res_status = bsgt_pkg::ST_QUEUE_FULL;
          end else begin
            cnt_d      = cnt_q + 8'd1;
            res_status = bsgt_pkg::ST_ACCEPTED;
          end
        end
      end
    end
    win_ctrl.shift = out_adv && record;
    win_ctrl.flush = out_adv && sess_upd && new_sess_q;
  end

  // the window hit is stale after a session change; the window then counts as empty
  assign win_hit = win_hit_raw;
  assign hit     = win_hit && !new_sess_q;

  bsgt_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (win_ctrl),
    .push_value_i (bnum_q),
    .probe_i      (bnum_q),
    .hit_o        (win_hit_raw)
  );

  // ---------------- state machine
  always_comb begin
    st_d = st_q;
    case (st_q)
      bsgt_pkg::FSM_IDLE: begin
        if (in_acc) begin
          st_d = bsgt_pkg::FSM_CMP;
        end
      end
      bsgt_pkg::FSM_CMP: begin
        st_d = bsgt_pkg::FSM_DEC;
      end
      bsgt_pkg::FSM_DEC: begin
        if (out_adv) begin
          st_d = bsgt_pkg::FSM_IDLE;
        end
      end
      default: begin
        st_d = bsgt_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bsgt_pkg::FSM_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rej_q  <= 1'b0;
      cap_q  <= 8'd16;
      max_q  <= 16'd1024;
      open_q <= 1'b0;
      cur_q  <= '0;
      hwv_q  <= 1'b0;
      high_q <= '0;
      exp_q  <= '0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (bsgt_pkg::cfg_idx_e'(cfg_i.reg_index))
          bsgt_pkg::CFG_REJECT_ON_GAP:  rej_q <= cfg_i.wdata[0];
          bsgt_pkg::CFG_QUEUE_CAPACITY: cap_q <= cfg_i.wdata[7:0];
          bsgt_pkg::CFG_MAX_SAMPLES:    max_q <= cfg_i.wdata;
          default: ;
        endcase
      end
      if (out_adv) begin
        cnt_q <= cnt_d;
        if (sess_upd) begin
          open_q <= 1'b1;
          cur_q  <= tag_q;
        end
        if (record && adv_q) begin
          hwv_q  <= 1'b1;
          high_q <= bnum_q;
          exp_q  <= end_q;
        end else if (sess_upd && new_sess_q) begin
          hwv_q <= 1'b0;
        end
      end
      if (out_adv) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_i.mode;
      tag_q  <= in_i.session_tag;
      bnum_q <= in_i.batch_number;
      fnum_q <= in_i.first_sample_number;
      nsmp_q <= in_i.samples_in_batch;
    end
    if (st_q == bsgt_pkg::FSM_CMP) begin
      new_sess_q  <= new_sess_c;
      restarted_q <= open_q && new_sess_c;
      invalid_q   <= (nsmp_q == 16'd0) || (nsmp_q > max_q);
      bgap_q      <= hwv_eff && b_above && (bdiff != 64'd1);
      bmiss_q     <= (hwv_eff && b_above && (bdiff != 64'd1)) ? bdiff - 64'd1 : '0;
      breord_q    <= hwv_eff && (bnum_q < high_q);
      sgap_q      <= hwv_eff && (fnum_q > exp_q);
      smiss_q     <= (hwv_eff && (fnum_q > exp_q)) ? fnum_q - exp_q : '0;
      sreord_q    <= hwv_eff && (fnum_q < exp_q);
      adv_q       <= !hwv_eff || b_above;
      end_q       <= sum65[64] ? bsgt_pkg::U64_TOP : sum65[63:0];
    end
    if (out_adv) begin
      o_status_q  <= res_status;
      o_restart_q <= r_restart;
      o_bgap_q    <= r_bgap;
      o_bmiss_q   <= r_bmiss;
      o_breord_q  <= r_breord;
      o_sgap_q    <= r_sgap;
      o_smiss_q   <= r_smiss;
      o_sreord_q  <= r_sreord;
      o_fill_q    <= cnt_d;
    end
  end

  assign out_o.valid             = ov_q;
  assign out_o.status            = o_status_q;
  assign out_o.session_restarted = o_restart_q;
  assign out_o.batch_gap_seen    = o_bgap_q;
  assign out_o.batches_missing   = o_bmiss_q;
  assign out_o.batch_reordered   = o_breord_q;
  assign out_o.sample_gap_seen   = o_sgap_q;
  assign out_o.samples_missing   = o_smiss_q;
  assign out_o.samples_reordered = o_sreord_q;
  assign out_o.queue_fill        = o_fill_q;

  // ---------------- assertions
  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (st_q == bsgt_pkg::FSM_CMP))
    else $error("accepted beat did not enter compare");

  a_dec_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_adv |=> (ov_q && (st_q == bsgt_pkg::FSM_IDLE)))
    else $error("decision did not load the result register");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + 8'd1) || (cnt_q == $past(cnt_q) - 8'd1)))
    else $error("queue count moved by more than one");

  a_accepted_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_adv && (res_status == bsgt_pkg::ST_ACCEPTED)) |=> (cnt_q != 8'd0))
    else $error("accepted batch left the queue empty");

  a_flush_with_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_ctrl.flush |-> win_ctrl.shift)
    else $error("window cleared without recording the new batch");

endmodule

// File: tb/bsgt_tracker_check.sv
// Checker for the batch sequence gap tracker: mirrors its state and compares every result beat.
module bsgt_tracker_check import bsgt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bsgt_in_if   in_i,
  bsgt_out_if  out_i,
  bsgt_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e     status;
    logic        restarted;
    logic        bgap;
    logic [63:0] bmiss;
    logic        breord;
    logic        sgap;
    logic [63:0] smiss;
    logic        sreord;
    logic [7:0]  fill;
  } verdict_t;

  logic        reject_gap;
  logic [7:0]  capacity;
  logic [15:0] max_samples;

  logic        sess_open;
  logic [63:0] sess_tag;
  logic        mark_valid;
  logic [63:0] top_batch;
  logic [63:0] next_sample;
  logic [63:0] seen_batch [HISTORY_DEPTH];
  logic        seen_valid [HISTORY_DEPTH];
  int unsigned seen_wptr;
  logic [7:0]  fill;

  verdict_t    verdicts_due [$];
  int          mismatches = 0;

  function automatic verdict_t track_batch(input logic mode, input logic [63:0] tag,
                                           input logic [63:0] b, input logic [63:0] f,
                                           input logic [15:0] n);
    verdict_t    v;
    logic [64:0] sample_end;
    logic        hit;
    v   = '0;
    hit = 1'b0;
    if (mode) begin
      if (fill != 8'd0) begin
        fill     = fill - 8'd1;
        v.status = ST_POPPED;
      end else begin
        v.status = ST_EMPTY;
      end
    end else if (n == 16'd0 || n > max_samples) begin
      v.status = ST_INVALID;
    end else begin
      if (!sess_open || sess_tag != tag) begin
        v.restarted = sess_open;
        sess_open   = 1'b1;
        sess_tag    = tag;
        mark_valid  = 1'b0;
        foreach (seen_valid[i]) seen_valid[i] = 1'b0;
        seen_wptr = 0;
      end
      foreach (seen_valid[i]) begin
        if (seen_valid[i] && seen_batch[i] == b) hit = 1'b1;
      end
      if (hit) begin
        v.status = ST_DUPLICATE;
      end else begin
        if (mark_valid) begin
          if (top_batch != U64_TOP && b > top_batch + 64'd1) begin
            v.bgap  = 1'b1;
            v.bmiss = b - top_batch - 64'd1;
          end else if (b < top_batch) begin
            v.breord = 1'b1;
          end
          if (f > next_sample) begin
            v.sgap  = 1'b1;
            v.smiss = f - next_sample;
          end else if (f < next_sample) begin
            v.sreord = 1'b1;
          end
        end
        if ((v.bgap || v.sgap) && reject_gap) begin
          v.status = ST_GAP_REJECTED;
        end else begin
          seen_batch[seen_wptr] = b;
          seen_valid[seen_wptr] = 1'b1;
          seen_wptr = (seen_wptr + 1) % HISTORY_DEPTH;
          if (!mark_valid || b > top_batch) begin
            mark_valid  = 1'b1;
            top_batch   = b;
            sample_end  = {1'b0, f} + {49'd0, n};
            next_sample = sample_end[64] ? U64_TOP : sample_end[63:0];
          end
          if (fill >= capacity) begin
            v.status = ST_QUEUE_FULL;
          end else begin
            fill     = fill + 8'd1;
            v.status = ST_ACCEPTED;
          end
        end
      end
    end
    v.fill = fill;
    return v;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      reject_gap  = 1'b0;
      capacity    = 8'd16;
      max_samples = 16'd1024;
      sess_open   = 1'b0;
      sess_tag    = '0;
      mark_valid  = 1'b0;
      top_batch   = '0;
      next_sample = '0;
      foreach (seen_valid[i]) begin
        seen_valid[i] = 1'b0;
        seen_batch[i] = '0;
      end
      seen_wptr = 0;
      fill      = 8'd0;
      verdicts_due.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.reg_index))
          CFG_REJECT_ON_GAP:  reject_gap  = cfg_i.wdata[0];
          CFG_QUEUE_CAPACITY: capacity    = cfg_i.wdata[7:0];
          CFG_MAX_SAMPLES:    max_samples = cfg_i.wdata;
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat, status %0d", out_i.status);
        end else begin
          want = verdicts_due[0];
          verdicts_due.delete(0);
          check_field("status", want.status, out_i.status);
          check_field("session_restarted", want.restarted, out_i.session_restarted);
          check_field("batch_gap_seen", want.bgap, out_i.batch_gap_seen);
          check_field("batches_missing", want.bmiss, out_i.batches_missing);
          check_field("batch_reordered", want.breord, out_i.batch_reordered);
          check_field("sample_gap_seen", want.sgap, out_i.sample_gap_seen);
          check_field("samples_missing", want.smiss, out_i.samples_missing);
          check_field("samples_reordered", want.sreord, out_i.samples_reordered);
          check_field("queue_fill", want.fill, out_i.queue_fill);
        end
      end
      if (in_i.valid && in_i.ready) begin
        verdicts_due.insert(verdicts_due.size(),
                            track_batch(in_i.mode, in_i.session_tag, in_i.batch_number,
                                        in_i.first_sample_number, in_i.samples_in_batch));
      end
      pending_o    <= verdicts_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: tb/tb.sv
// Testbench top for the batch sequence gap tracker: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsgt_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   snd_idle = 7;
  int   rcv_idle = 63;

  // stimulus cursor: where the current session would continue in order
  logic [63:0] cur_tag    = '0;
  logic [63:0] next_batch = '0;
  logic [63:0] next_first = '0;
  logic [15:0] max_cnt    = 16'd1024;
  logic [63:0] sent_batches [$];

  bsgt_in_if  in_ch ();
  bsgt_out_if out_ch ();
  bsgt_cfg_if cfg_ch ();

  batch_sequence_gap_tracker_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  bsgt_tracker_check check_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(input logic mode, input logic [63:0] tag, input logic [63:0] b,
                           input logic [63:0] f, input logic [15:0] n);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid               <= 1'b1;
    in_ch.mode                <= mode;
    in_ch.session_tag         <= tag;
    in_ch.batch_number        <= b;
    in_ch.first_sample_number <= f;
    in_ch.samples_in_batch    <= n;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic pop_beat();
    push_item(1'b1, rand64(), rand64(), rand64(), 16'($urandom));
  endtask

  task automatic submit(input logic [63:0] tag, input logic [63:0] b, input logic [63:0] f,
                        input logic [15:0] n);
    push_item(1'b0, tag, b, f, n);
    if (n != 16'd0 && n <= max_cnt) begin
      if (tag != cur_tag) sent_batches.delete();
      if (sent_batches.size() >= HISTORY_DEPTH) sent_batches.delete(0);
      sent_batches.insert(sent_batches.size(), b);
      if (tag != cur_tag || b >= next_batch) begin
        next_batch = b + 64'd1;
        next_first = f + 64'(n);
      end
      cur_tag = tag;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic reject, input logic [7:0] cap, input logic [15:0] lim);
    drain();
    write_reg(CFG_REJECT_ON_GAP, {15'd0, reject});
    write_reg(CFG_QUEUE_CAPACITY, {8'd0, cap});
    write_reg(CFG_MAX_SAMPLES, lim);
    cfg_ch.valid <= 1'b0;
    max_cnt = lim;
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [63:0] tag;
    logic [63:0] b;
    logic [63:0] f;
    logic [15:0] n;
    pick = $urandom_range(0, 99);
    tag  = cur_tag;
    b    = next_batch;
    f    = next_first;
    if ($urandom_range(0, 15) == 0) n = max_cnt;
    else n = 16'($urandom_range(1, (max_cnt < 16'd64) ? max_cnt : 16'd64));
    if (pick < 22) begin
      pop_beat();
    end else begin
      if (pick < 27) begin
        if ($urandom_range(0, 1) == 0 || max_cnt == 16'hFFFF) n = 16'd0;
        else n = 16'($urandom_range(max_cnt + 1, 16'hFFFF));
      end else if (pick < 31) begin
        tag = rand64();
        case ($urandom_range(0, 2))
          0: begin
            b = rand64();
            f = rand64();
          end
          1: begin
            b = U64_TOP - $urandom_range(0, 3);
            f = U64_TOP - $urandom_range(0, 200);
          end
          default: begin
            b = 64'($urandom_range(0, 3));
            f = 64'($urandom_range(0, 3));
          end
        endcase
      end else if (pick < 40) begin
        b = next_batch + $urandom_range(1, 6);
        if ($urandom_range(0, 1) == 1) f = next_first + $urandom_range(1, 500);
      end else if (pick < 45) begin
        f = next_first + $urandom_range(1, 9);
      end else if (pick < 50) begin
        b = next_batch - $urandom_range(2, 8);
        f = next_first - $urandom_range(1, 300);
      end else if (pick < 55 && sent_batches.size() != 0) begin
        b = sent_batches[$urandom_range(0, sent_batches.size() - 1)];
      end else if (pick < 58) begin
        b = rand64();
        f = rand64();
      end
      submit(tag, b, f, n);
    end
  endtask

  // receiver side
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    logic [63:0] tag;
    in_ch.valid               = 1'b0;
    in_ch.mode                = 1'b0;
    in_ch.session_tag         = '0;
    in_ch.batch_number        = '0;
    in_ch.first_sample_number = '0;
    in_ch.samples_in_batch    = '0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.reg_index          = CFG_REJECT_ON_GAP;
    cfg_ch.wdata              = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset configuration
    push_item(1'b1, '0, '0, '0, '0);
    submit(64'hA5A5_0000_0000_0001, 64'd10, 64'd100, 16'd0);
    submit(64'hA5A5_0000_0000_0001, 64'd10, 64'd100, 16'd1025);
    submit(64'hA5A5_0000_0000_0001, 64'd10, 64'd100, 16'hFFFF);
    submit(64'hA5A5_0000_0000_0001, 64'd10, 64'd100, 16'd5);
    submit(64'hA5A5_0000_0000_0001, 64'd11, 64'd105, 16'd1024);
    submit(64'hA5A5_0000_0000_0001, 64'd11, 64'd1129, 16'd1);
    submit(64'hA5A5_0000_0000_0001, 64'd15, 64'd2000, 16'd4);
    submit(64'hA5A5_0000_0000_0001, 64'd12, 64'd50, 16'd4);
    submit(64'h5A5A_FFFF_FFFF_FFFE, 64'd11, 64'd0, 16'd1);
    push_item(1'b1, '0, '0, '0, '0);
    submit(64'h5A5A_FFFF_FFFF_FFFE, U64_TOP, U64_TOP - 64'd2, 16'd100);
    submit(64'h5A5A_FFFF_FFFF_FFFE, 64'd0, U64_TOP, 16'd1);
    submit(U64_TOP, 64'd0, 64'd0, 16'd1);
    submit(U64_TOP, 64'd1, 64'd1, 16'd1);

    configure(1'b1, 8'd255, 16'hFFFF);
    submit(U64_TOP, 64'd5, 64'd2, 16'd1);
    submit(U64_TOP, 64'd5, 64'd2, 16'd1);
    submit(U64_TOP, 64'd2, 64'd9, 16'd1);
    submit(U64_TOP, 64'd2, 64'd2, 16'd1);
    repeat (120) random_item();

    snd_idle = 63;
    rcv_idle = 7;
    configure(1'b0, 8'd1, 16'd1);
    repeat (120) random_item();

    snd_idle = 0;
    rcv_idle = 0;
    configure(1'b1, 8'd16, 16'd300);
    // top batch number stays the high-water mark while the window rolls over
    tag = rand64();
    submit(tag, U64_TOP, 64'd1000, 16'd5);
    for (int i = 0; i < HISTORY_DEPTH; i++) submit(tag, 64'd100 + 64'(i), 64'd1005, 16'd1);
    submit(tag, U64_TOP, 64'd1005, 16'd5);
    repeat (120) random_item();

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS batch_sequence_gap_tracker_top");
    end else begin
      $display("FAIL batch_sequence_gap_tracker_top");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL batch_sequence_gap_tracker_top");
    $finish;
  end

endmodule

// File: sim.f
rtl/bsgt_pkg.sv
rtl/bsgt_if.sv
rtl/bsgt_cell.sv
rtl/bsgt_window.sv
rtl/batch_sequence_gap_tracker_top.sv
tb/bsgt_tracker_check.sv
tb/tb.sv
